// ===== src/bpa_pkg.sv =====
// Package for the bitmap page allocator: pool geometry, opcodes, FSM states
// and small helpers. No dependencies; imported by the interfaces, RAM users and top level.
package bpa_pkg;

  localparam int PAGE_COUNT = 1024;
  localparam int PAGE_BYTES = 4096;
  localparam int ROW_BITS   = 64;
  localparam int ROW_COUNT  = (PAGE_COUNT + ROW_BITS - 1) / ROW_BITS;

  // Field widths of the request and response beats
  localparam int ADDR_W  = 32;
  localparam int LEN_W   = 32;
  localparam int PAGE_W  = 10;

  localparam int OFFSET_W = $clog2(PAGE_BYTES);
  localparam int COL_W    = $clog2(ROW_BITS);
  localparam int ROW_W    = $clog2(ROW_COUNT);
  localparam int EVAL_W   = $clog2(ROW_COUNT + 1);

  localparam logic [ADDR_W:0] POOL_SPAN = (ADDR_W + 1)'(PAGE_COUNT * PAGE_BYTES);
  localparam logic [LEN_W-1:0] PAGE_LEN = LEN_W'(PAGE_BYTES);

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Next bitmap row with wraparound
  function automatic logic [ROW_W-1:0] row_after(input logic [ROW_W-1:0] r);
    logic [ROW_W-1:0] n;
    if (r == ROW_W'(ROW_COUNT - 1)) begin
      n = '0;
    end else begin
      n = r + ROW_W'(1);
    end
    return n;
  endfunction

endpackage

// ===== src/bpa_if.sv =====
// Valid/ready channels of the bitmap page allocator: request, response and
// configuration write. Depends on bpa_pkg for the field widths.
interface bpa_req_if import bpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [LEN_W-1:0]  request_length;
  logic [PAGE_W-1:0] start_page;
  logic [ADDR_W-1:0] release_address;

  modport source (output valid, operation, request_length, start_page, release_address,
                  input ready);
  modport sink   (input valid, operation, request_length, start_page, release_address,
                  output ready);
endinterface

interface bpa_rsp_if import bpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              success;
  logic [ADDR_W-1:0] grant_address;
  logic [PAGE_W-1:0] page_number;

  modport source (output valid, success, grant_address, page_number, input ready);
  modport sink   (input valid, success, grant_address, page_number, output ready);
endinterface

interface bpa_cfg_if import bpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== src/bpa_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bpa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== src/bitmap_page_allocator.sv =====
// Bitmap page allocator: one bit per page held in a 16 x 64 RAM, read one row a cycle.
// Release or failed length: decided on the first row read, then the done state loads the response register.
// Allocate: one row per cycle from the start row, wrapping, up to 17 rows, then the done state as above.
// One item at a time: a new request is taken only in idle; the done state waits while the response register is full.
// Reset (rst, synchronous): every page free via per-row valid bits, pool_base 0, no response.
// Depends on bpa_pkg, bpa_if and bpa_ram.
module bitmap_page_allocator import bpa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  bpa_cfg_if.sink   cfg,
  bpa_req_if.sink   req,
  bpa_rsp_if.source rsp
);

  state_t state, state_next;

  logic [ADDR_W-1:0]   pool_base;
  logic                op, op_next;
  logic                too_long, too_long_next;
  logic                in_range, in_range_next;
  logic [COL_W-1:0]    first, first_next;
  logic [PAGE_W-1:0]   rel_page, rel_page_next;
  logic [ROW_W-1:0]    scan_row, scan_row_next;
  logic [ROW_W-1:0]    eval_row, eval_row_next;
  logic [EVAL_W-1:0]   evals, evals_next;
  logic                ok, ok_next;
  logic [PAGE_W-1:0]   page, page_next;
  logic [ROW_BITS-1:0] row_new, row_new_next;
  logic [ROW_COUNT-1:0] row_valid;

  logic                out_valid, out_valid_next;
  logic                out_success, out_success_next;
  logic [ADDR_W-1:0]   out_address, out_address_next;
  logic [PAGE_W-1:0]   out_page, out_page_next;

  logic                ram_wr_en;
  logic [ROW_W-1:0]    ram_rd_addr;
  logic [ROW_BITS-1:0] ram_rd_data;

  // Request decode while idle
  logic                accept;
  logic [ADDR_W:0]     rel_diff;
  logic                rel_ok;
  logic [PAGE_W-1:0]   rel_pg;
  logic [ROW_W-1:0]    in_row;

  // Row search
  logic [ROW_BITS-1:0] row_data;
  logic [ROW_BITS-1:0] lo_mask;
  logic [ROW_BITS-1:0] search_mask;
  logic [ROW_BITS-1:0] free_bits;
  logic [ROW_BITS-1:0] iso;
  logic [COL_W-1:0]    free_col;
  logic [ROW_BITS-1:0] pat;
  logic                found;
  logic                out_load;

  assign cfg.ready = 1'b1;
  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;

  assign rsp.valid         = out_valid;
  assign rsp.success       = out_success;
  assign rsp.grant_address = out_address;
  assign rsp.page_number   = out_page;

  assign rel_diff = {1'b0, req.release_address} - {1'b0, pool_base};
  assign rel_ok   = !rel_diff[ADDR_W] && ({1'b0, rel_diff[ADDR_W-1:0]} < POOL_SPAN);
  assign rel_pg   = rel_diff[OFFSET_W +: PAGE_W];
  assign in_row   = (req.operation == OP_RELEASE) ? rel_pg[COL_W +: ROW_W]
                                                  : req.start_page[COL_W +: ROW_W];

  assign ram_rd_addr = (state == ST_IDLE) ? in_row : scan_row;
  assign ram_wr_en   = (state == ST_DONE) && ok;

  bpa_ram #(
    .WIDTH(ROW_BITS),
    .DEPTH(ROW_COUNT)
  ) u_bitmap (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(eval_row),
    .wr_data(row_new),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  // A row never written since reset reads as all free
  assign row_data = row_valid[eval_row] ? ram_rd_data : '0;
  assign lo_mask  = {ROW_BITS{1'b1}} << first;

  always_comb begin
    if (evals == EVAL_W'(0)) begin
      search_mask = lo_mask;
    end else if (evals == EVAL_W'(ROW_COUNT)) begin
      search_mask = ~lo_mask;
    end else begin
      search_mask = {ROW_BITS{1'b1}};
    end
  end

  assign free_bits = ~row_data & search_mask;
  assign iso       = free_bits & (~free_bits + ROW_BITS'(1));
  assign found     = |free_bits;

  always_comb begin
    for (int b = 0; b < COL_W; b++) begin
      for (int j = 0; j < ROW_BITS; j++) begin
        pat[j] = ((j >> b) & 1) == 1;
      end
      free_col[b] = |(iso & pat);
    end
  end

  assign out_load = (state == ST_DONE) && (!out_valid || rsp.ready);

  always_comb begin
    state_next       = state;
    op_next          = op;
    too_long_next    = too_long;
    in_range_next    = in_range;
    first_next       = first;
    rel_page_next    = rel_page;
    scan_row_next    = scan_row;
    eval_row_next    = eval_row;
    evals_next       = evals;
    ok_next          = ok;
    page_next        = page;
    row_new_next     = row_new;
    out_valid_next   = out_valid && !rsp.ready;
    out_success_next = out_success;
    out_address_next = out_address;
    out_page_next    = out_page;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          op_next       = req.operation;
          too_long_next = req.request_length > PAGE_LEN;
          in_range_next = rel_ok;
          first_next    = req.start_page[COL_W-1:0];
          rel_page_next = rel_pg;
          eval_row_next = in_row;
          scan_row_next = row_after(in_row);
          evals_next    = '0;
          state_next    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Issue the next row read every cycle; the data in hand belongs to eval_row
        scan_row_next = row_after(scan_row);
        if (op == OP_RELEASE) begin
          ok_next      = in_range;
          page_next    = rel_page;
          row_new_next = row_data & ~(ROW_BITS'(1) << rel_page[COL_W-1:0]);
          state_next   = ST_DONE;
        end else if (too_long) begin
          ok_next    = 1'b0;
          state_next = ST_DONE;
        end else if (found) begin
          ok_next      = 1'b1;
          page_next    = {eval_row, free_col};
          row_new_next = row_data | iso;
          state_next   = ST_DONE;
        end else if (evals == EVAL_W'(ROW_COUNT)) begin
          ok_next    = 1'b0;
          state_next = ST_DONE;
        end else begin
          evals_next    = evals + EVAL_W'(1);
          eval_row_next = row_after(eval_row);
        end
      end
      ST_DONE: begin
        // Hold until the output register is free; the row write repeats harmlessly
        if (out_load) begin
          out_valid_next   = 1'b1;
          out_success_next = ok;
          out_address_next = ok ? pool_base + ADDR_W'({page, {OFFSET_W{1'b0}}}) : '0;
          out_page_next    = ok ? page : '0;
          state_next       = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      row_valid <= '0;
      pool_base <= '0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      if (ram_wr_en) begin
        row_valid[eval_row] <= 1'b1;
      end
      if (cfg.valid && cfg.ready) begin
        pool_base <= cfg.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    op          <= op_next;
    too_long    <= too_long_next;
    in_range    <= in_range_next;
    first       <= first_next;
    rel_page    <= rel_page_next;
    scan_row    <= scan_row_next;
    eval_row    <= eval_row_next;
    evals       <= evals_next;
    ok          <= ok_next;
    page        <= page_next;
    row_new     <= row_new_next;
    out_success <= out_success_next;
    out_address <= out_address_next;
    out_page    <= out_page_next;
  end

  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_SCAN)
    else $error("request beat did not start a scan");

  a_read_ahead: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> scan_row == row_after(eval_row))
    else $error("read pointer out of step with evaluated row");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> evals <= EVAL_W'(ROW_COUNT))
    else $error("scan ran past the wrap back to the start row");

  a_alloc_marks: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && ok && op == OP_ALLOC) |-> row_new[page[COL_W-1:0]])
    else $error("granted page not marked used");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_success) |-> (out_address == '0 && out_page == '0))
    else $error("failed response carries a page");

endmodule

// ===== verif/tb_bitmap_page_allocator.sv =====
`timescale 1ns / 1ps
// Testbench for bitmap_page_allocator: directed and random allocate/release beats
// checked against an in-bench bitmap predictor. Depends on bpa_pkg, bpa_if and bitmap_page_allocator.
module tb_bitmap_page_allocator;
  import bpa_pkg::*;

  typedef struct packed {
    logic              success;
    logic [ADDR_W-1:0] grant_address;
    logic [PAGE_W-1:0] page_number;
  } grant_t;

  class allocation_tracker;
    bit [PAGE_COUNT-1:0] page_used;
    bit [ADDR_W-1:0]     pool_base;
    grant_t              pending_grants[$];
    int                  mismatches;

    function new();
      page_used  = '0;
      pool_base  = '0;
      mismatches = 0;
    endfunction

    function void set_pool_base(logic [ADDR_W-1:0] value);
      pool_base = value;
    endfunction

    function int pending();
      return pending_grants.size();
    endfunction

    function grant_t predict_grant(logic op, logic [LEN_W-1:0] len,
                                   logic [PAGE_W-1:0] start, logic [ADDR_W-1:0] addr);
      grant_t          g;
      int unsigned     p;
      longint unsigned offset;
      g = '0;
      if (op == OP_ALLOC) begin
        if (len <= PAGE_LEN) begin
          for (int i = 0; i < PAGE_COUNT; i++) begin
            p = (int'(start) + i) % PAGE_COUNT;
            if (!page_used[p]) begin
              page_used[p] = 1'b1;
              g.success    = 1'b1;
              break;
            end
          end
        end
      end else begin
        // exact comparison: an address that wrapped below the base is outside
        if (addr >= pool_base) begin
          offset = longint'(addr) - longint'(pool_base);
          if (offset < longint'(PAGE_COUNT) * longint'(PAGE_BYTES)) begin
            p            = int'(offset / PAGE_BYTES);
            page_used[p] = 1'b0;
            g.success    = 1'b1;
          end
        end
      end
      if (g.success) begin
        g.grant_address = pool_base + ADDR_W'(p) * ADDR_W'(PAGE_BYTES);
        g.page_number   = PAGE_W'(p);
      end
      return g;
    endfunction

    function void note_request(logic op, logic [LEN_W-1:0] len,
                               logic [PAGE_W-1:0] start, logic [ADDR_W-1:0] addr);
      pending_grants.push_back(predict_grant(op, len, start, addr));
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    task check_grant(logic success, logic [ADDR_W-1:0] grant_address,
                     logic [PAGE_W-1:0] page_number);
      grant_t want;
      if (pending_grants.size() == 0) begin
        report_mismatch("response beat with nothing outstanding");
      end else begin
        want = pending_grants.pop_front();
        if (success !== want.success)
          report_mismatch($sformatf("success %0b, want %0b", success, want.success));
        if (grant_address !== want.grant_address)
          report_mismatch($sformatf("grant_address %h, want %h", grant_address,
                                    want.grant_address));
        if (page_number !== want.page_number)
          report_mismatch($sformatf("page_number %0d, want %0d", page_number,
                                    want.page_number));
      end
    endtask
  endclass

  logic clk;
  logic rst;
  int   src_idle_pct;
  int   sink_idle_pct;

  allocation_tracker board;

  bpa_req_if req_ch();
  bpa_rsp_if rsp_ch();
  bpa_cfg_if cfg_ch();

  bitmap_page_allocator dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Response back-pressure, one decision per cycle
  always @(negedge clk) begin
    rsp_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) board.set_pool_base(cfg_ch.data);
      if (req_ch.valid && req_ch.ready)
        board.note_request(req_ch.operation, req_ch.request_length, req_ch.start_page,
                           req_ch.release_address);
      if (rsp_ch.valid && rsp_ch.ready)
        board.check_grant(rsp_ch.success, rsp_ch.grant_address, rsp_ch.page_number);
    end
  end

  task automatic send_item(logic op, logic [LEN_W-1:0] len, logic [PAGE_W-1:0] start,
                           logic [ADDR_W-1:0] addr);
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid           <= 1'b1;
    req_ch.operation       <= op;
    req_ch.request_length  <= len;
    req_ch.start_page      <= start;
    req_ch.release_address <= addr;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Drop request valid and wait until every response has drained
  task automatic drain();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  task automatic write_pool_base(logic [ADDR_W-1:0] value);
    drain();
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_random(int count, int alloc_pct);
    logic              op;
    logic [LEN_W-1:0]  len;
    logic [ADDR_W-1:0] addr;
    int                pick;
    for (int n = 0; n < count; n++) begin
      op   = ($urandom_range(0, 99) < alloc_pct) ? OP_ALLOC : OP_RELEASE;
      pick = $urandom_range(0, 99);
      if (pick < 70)      len = LEN_W'($urandom_range(0, PAGE_BYTES));
      else if (pick < 78) len = PAGE_LEN;
      else if (pick < 84) len = PAGE_LEN + 1;
      else if (pick < 88) len = '0;
      else                len = $urandom();
      addr = $urandom();
      // most releases land inside the pool, the rest anywhere
      if (op == OP_RELEASE && $urandom_range(0, 99) < 82)
        addr = board.pool_base + ADDR_W'($urandom_range(0, PAGE_COUNT - 1)) * PAGE_BYTES
               + ADDR_W'($urandom_range(0, PAGE_BYTES - 1));
      send_item(op, len, PAGE_W'($urandom_range(0, PAGE_COUNT - 1)), addr);
    end
  endtask

  initial begin
    board                  = new();
    rst                    = 1'b1;
    src_idle_pct           = 0;
    sink_idle_pct          = 0;
    req_ch.valid           = 1'b0;
    req_ch.operation       = OP_ALLOC;
    req_ch.request_length  = '0;
    req_ch.start_page      = '0;
    req_ch.release_address = '0;
    rsp_ch.ready           = 1'b0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.data            = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: pool at address zero after reset
    src_idle_pct  = 6;
    sink_idle_pct = 68;
    send_item(OP_ALLOC, '0, 10'd0, '0);
    send_item(OP_ALLOC, PAGE_LEN, 10'd0, '0);
    send_item(OP_ALLOC, PAGE_LEN + 1, 10'd0, '0);
    send_item(OP_ALLOC, 32'hFFFF_FFFF, 10'd1023, '0);
    send_item(OP_ALLOC, 32'd1, 10'd1023, 32'hFFFF_FFFF);
    send_item(OP_ALLOC, PAGE_LEN, 10'd1023, '0);
    send_item(OP_RELEASE, '0, 10'd0, 32'h0000_0000);
    send_item(OP_RELEASE, 32'hFFFF_FFFF, 10'd1023, 32'h0000_0000);
    send_item(OP_RELEASE, '0, 10'd0, PAGE_COUNT * PAGE_BYTES - 1);
    send_item(OP_RELEASE, '0, 10'd0, PAGE_COUNT * PAGE_BYTES);
    send_item(OP_RELEASE, '0, 10'd0, 32'hFFFF_FFFF);
    send_item(OP_ALLOC, 32'h8000_0000, 10'd512, '0);

    // Pool straddling the top of the address space
    write_pool_base(32'hFFFF_F000);
    send_item(OP_ALLOC, 32'd100, 10'd1023, '0);
    send_item(OP_RELEASE, '0, 10'd0, 32'hFFFF_F000);
    send_item(OP_RELEASE, '0, 10'd0, 32'h0000_1000);
    send_item(OP_RELEASE, '0, 10'd0, 32'hFFFF_EFFF);
    send_item(OP_RELEASE, '0, 10'd0, 32'hFFFF_FFFF);

    write_pool_base(32'hFFFF_FFFF);
    send_item(OP_RELEASE, '0, 10'd0, 32'hFFFF_FFFF);
    send_item(OP_RELEASE, '0, 10'd0, 32'h0000_0000);
    send_item(OP_ALLOC, PAGE_LEN, 10'd5, '0);

    write_pool_base(32'h1234_5000);
    send_item(OP_RELEASE, '0, 10'd0, 32'h1234_5000 + 3 * PAGE_BYTES + 7);
    send_item(OP_RELEASE, '0, 10'd0, 32'h1234_4FFF);
    send_item(OP_ALLOC, 32'd2048, 10'd511, '0);

    // Random: two allocation-heavy runs, then a release-heavy run
    write_pool_base($urandom());
    src_idle_pct  = 6;
    sink_idle_pct = 68;
    run_random(560, 97);

    write_pool_base(32'hFFC0_0000);
    src_idle_pct  = 68;
    sink_idle_pct = 6;
    run_random(560, 97);

    write_pool_base(32'h0000_0000);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    run_random(430, 40);

    drain();
    if (board.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
